### rtl/core/terminal_line_discipline_defines.svh
// Assertion macros for the terminal line discipline checker
`ifndef TERMINAL_LINE_DISCIPLINE_DEFINES_SVH
`define TERMINAL_LINE_DISCIPLINE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define TLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/tld_pkg.sv
// Package for the terminal line discipline: types, codes, constants
package tld_pkg;
    localparam int LINE_DEPTH_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 256;

    localparam logic [1:0] CMD_RECV    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_DISCARD = 2'd2;

    localparam logic [2:0] K_ECHO   = 3'd0;
    localparam logic [2:0] K_RUBOUT = 3'd1;
    localparam logic [2:0] K_SIGNAL = 3'd2;
    localparam logic [2:0] K_READ   = 3'd3;
    localparam logic [2:0] K_EOF    = 3'd4;
    localparam logic [2:0] K_EMPTY  = 3'd5;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_INTR = 3'd1;
    localparam logic [2:0] REG_QUIT = 3'd2;
    localparam logic [2:0] REG_SUSP = 3'd3;
    localparam logic [2:0] REG_ERASE = 3'd4;
    localparam logic [2:0] REG_KILL = 3'd5;
    localparam logic [2:0] REG_EOF  = 3'd6;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // classified operation from the front part
    typedef enum logic [3:0] {
        OP_NONE, OP_SIGNAL, OP_RAW, OP_ERASE, OP_KILL, OP_EOF,
        OP_NEWLINE, OP_STORE, OP_READ, OP_DISCARD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;   // byte after translation, or signal code
        logic [7:0] sig_ch; // byte that raised the signal
    } t_task;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [8:0] count;
        logic       lend;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_COMMIT, ST_RDWAIT, ST_EMIT
    } t_state;
endpackage

### rtl/core/tld_if.sv
// Valid/ready channel interfaces for the terminal line discipline
interface tld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] in_byte;
    modport source (output valid, cmd, in_byte, input ready);
    modport sink (input valid, cmd, in_byte, output ready);
endinterface

interface tld_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_kind;
    logic [7:0] data_byte;
    logic [8:0] rubout_count;
    logic       line_end;
    logic       last;
    modport source (output valid, result_kind, data_byte, rubout_count, line_end, last,
                    input ready);
    modport sink (input valid, result_kind, data_byte, rubout_count, line_end, last,
                  output ready);
endinterface

interface tld_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/core/tld_ram.sv
// Generic single-port-write, one-read RAM with registered read
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write-first: a read of the address being written returns the new word
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= (i_we && i_waddr == i_raddr) ? i_wdata : r_mem[i_raddr];
    end
endmodule

### rtl/core/tld_front.sv
// Front part: input translation and classification into tasks
module tld_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tld_in_if.sink             in_ch,
    input  logic [8:0]         i_mode,
    input  logic [7:0]         i_intr,
    input  logic [7:0]         i_quit,
    input  logic [7:0]         i_susp,
    input  logic [7:0]         i_erase,
    input  logic [7:0]         i_kill,
    input  logic [7:0]         i_eofc,
    output logic               o_push,
    output tld_pkg::t_task     o_task,
    input  logic               i_full
);
    import tld_pkg::*;
    logic [7:0] c1, c;
    logic       acc;

    assign in_ch.ready = !i_full;
    assign acc = in_ch.valid && !i_full;
    assign o_push = acc;

    // translation then classification
    always_comb begin
        c1 = in_ch.in_byte;
        o_task.op = OP_NONE;
        o_task.sig_ch = 8'd0;
        if (i_mode[0] && c1 == CH_CR) c1 = CH_NL;
        c = c1;
        if (i_mode[2] && c1 == CH_NL) c = CH_CR;
        o_task.data = c;
        case (in_ch.cmd)
            CMD_RECV: begin
                if (!i_mode[0] && i_mode[1] && in_ch.in_byte == CH_CR) begin
                    o_task.op = OP_NONE;
                end else if (i_mode[3] && (c == i_intr || c == i_quit || c == i_susp)) begin
                    o_task.op = OP_SIGNAL;
                    o_task.sig_ch = c;
                    o_task.data = (c == i_intr) ? 8'd0 : (c == i_quit) ? 8'd1 : 8'd2;
                end else if (!i_mode[4]) o_task.op = OP_RAW;
                else if (c == i_erase || c == CH_BS) o_task.op = OP_ERASE;
                else if (c == i_kill) o_task.op = OP_KILL;
                else if (c == i_eofc) o_task.op = OP_EOF;
                else if (c == CH_NL) o_task.op = OP_NEWLINE;
                else o_task.op = OP_STORE;
            end
            CMD_READ:    o_task.op = OP_READ;
            CMD_DISCARD: o_task.op = OP_DISCARD;
            default:     o_task.op = OP_NONE;
        endcase
    end

    logic unused;
    assign unused = i_clk ^ i_rst_n;
endmodule

### rtl/core/tld_queue.sv
// Short task queue between front and back parts
module tld_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tld_pkg::t_task i_task,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tld_pkg::t_task o_task
);
    import tld_pkg::*;
    localparam int AW = $clog2(DEPTH);
    t_task r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_task = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_task;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

### rtl/core/tld_back.sv
// Back part: edit line, ready ring, results sequencer
module tld_back #(
    parameter int LINE_DEPTH  = tld_pkg::LINE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = tld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [8:0]     i_mode,
    input  logic           i_empty,
    input  tld_pkg::t_task i_task,
    output logic           o_pop,
    output logic           o_idle,
    tld_out_if.source      out_ch
);
    import tld_pkg::*;
    localparam int LA = $clog2(LINE_DEPTH);
    localparam int QA = $clog2(QUEUE_DEPTH);

    t_state r_st, n_st;
    logic [LA:0] r_ecnt, n_ecnt;
    logic [QA-1:0] r_head, n_head;
    logic [QA:0] r_rcnt, n_rcnt;
    logic r_eofp, n_eofp;
    logic [LA:0] r_ci, n_ci;          // commit walk index
    t_result r_res [5];
    t_result n_res [5];
    logic [2:0] r_nres, n_nres, r_ri, n_ri;
    logic r_ov, n_ov;
    t_result r_out, n_out;

    // edit store and ready ring
    logic e_we; logic [LA-1:0] e_wa, e_ra; logic [7:0] e_wd, e_rd;
    logic q_we; logic [QA-1:0] q_wa; logic [7:0] q_wd, q_rd;
    tld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_edit (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));
    tld_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_ring (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(r_head), .o_rdata(q_rd));

    logic ofree;
    assign ofree = !r_ov || out_ch.ready;
    assign out_ch.valid = r_ov;
    assign out_ch.result_kind = r_out.kind;
    assign out_ch.data_byte = r_out.data;
    assign out_ch.rubout_count = r_out.count;
    assign out_ch.line_end = r_out.lend;
    assign out_ch.last = r_out.last;
    assign o_idle = r_st == ST_IDLE && i_empty && !r_ov;

    function automatic t_result mk(logic [2:0] k, logic [7:0] d, logic [8:0] n, logic l);
        t_result r;
        r.kind = k; r.data = d; r.count = n; r.lend = l; r.last = 1'b0;
        return r;
    endfunction

    logic [8:0] kill_n;
    always_comb begin
        kill_n = (r_ecnt > (LA+1)'(511)) ? 9'd511 : 9'(r_ecnt);
    end

    // control echo character; may itself be a newline
    logic [7:0] sig_at;
    assign sig_at = CH_AT + i_task.sig_ch;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (!i_empty) n_st = ST_EXEC;
            ST_EXEC: begin
                if (i_task.op == OP_READ && r_rcnt != '0) n_st = ST_RDWAIT;
                else if ((i_task.op == OP_NEWLINE) ||
                         (i_task.op == OP_EOF && r_ecnt != '0)) n_st = ST_COMMIT;
                else n_st = ST_EMIT;
            end
            ST_COMMIT: if (r_ci + 1'b1 >= r_ecnt) n_st = ST_EMIT;
            ST_RDWAIT: n_st = ST_EMIT;
            ST_EMIT: if (r_ri >= r_nres || (ofree && r_ri + 1'b1 >= r_nres)) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ecnt = r_ecnt; n_head = r_head; n_rcnt = r_rcnt; n_eofp = r_eofp;
        n_ci = r_ci; n_nres = r_nres; n_ri = r_ri; n_ov = r_ov; n_out = r_out;
        for (int k = 0; k < 5; k++) n_res[k] = r_res[k];
        e_we = 1'b0; e_wa = r_ecnt[LA-1:0]; e_wd = i_task.data; e_ra = '0;
        q_we = 1'b0; q_wa = r_head + r_rcnt[QA-1:0]; q_wd = i_task.data;
        o_pop = 1'b0;
        if (r_ov && out_ch.ready) n_ov = 1'b0;
        case (r_st)
            ST_IDLE: begin
                n_nres = '0; n_ri = '0; n_ci = '0;
            end
            ST_EXEC: begin
                o_pop = 1'b1;
                e_ra = '0;
                case (i_task.op)
                    OP_SIGNAL: begin
                        n_ecnt = '0;
                        if (i_mode[5]) begin
                            n_res[0] = mk(K_ECHO, CH_CARET, 9'd0, 1'b0);
                            if (i_mode[8] && sig_at == CH_NL) begin
                                // two CR LF pairs fill the five words; signal is lost
                                n_res[1] = mk(K_ECHO, CH_CR, 9'd0, 1'b0);
                                n_res[2] = mk(K_ECHO, CH_NL, 9'd0, 1'b0);
                                n_res[3] = mk(K_ECHO, CH_CR, 9'd0, 1'b0);
                                n_res[4] = mk(K_ECHO, CH_NL, 9'd0, 1'b0);
                                n_nres = 3'd5;
                            end else if (i_mode[8]) begin
                                n_res[1] = mk(K_ECHO, sig_at, 9'd0, 1'b0);
                                n_res[2] = mk(K_ECHO, CH_CR, 9'd0, 1'b0);
                                n_res[3] = mk(K_ECHO, CH_NL, 9'd0, 1'b0);
                                n_res[4] = mk(K_SIGNAL, i_task.data, 9'd0, 1'b0);
                                n_nres = 3'd5;
                            end else begin
                                n_res[1] = mk(K_ECHO, sig_at, 9'd0, 1'b0);
                                n_res[2] = mk(K_ECHO, CH_NL, 9'd0, 1'b0);
                                n_res[3] = mk(K_SIGNAL, i_task.data, 9'd0, 1'b0);
                                n_nres = 3'd4;
                            end
                        end else begin
                            n_res[0] = mk(K_SIGNAL, i_task.data, 9'd0, 1'b0);
                            n_nres = 3'd1;
                        end
                    end
                    OP_RAW, OP_STORE, OP_NEWLINE: begin
                        if (i_task.op == OP_RAW) begin
                            if (r_rcnt != (QA+1)'(QUEUE_DEPTH)) begin
                                q_we = 1'b1; n_rcnt = r_rcnt + 1'b1;
                            end
                        end else if (r_ecnt != (LA+1)'(LINE_DEPTH)) begin
                            e_we = 1'b1; n_ecnt = r_ecnt + 1'b1;
                        end
                        if (i_mode[5] && (i_task.op != OP_STORE ||
                                          r_ecnt != (LA+1)'(LINE_DEPTH))) begin
                            if (i_task.data == CH_NL && i_mode[8]) begin
                                n_res[0] = mk(K_ECHO, CH_CR, 9'd0, 1'b0);
                                n_res[1] = mk(K_ECHO, CH_NL, 9'd0, 1'b0);
                                n_nres = 3'd2;
                            end else begin
                                n_res[0] = mk(K_ECHO, i_task.data, 9'd0, 1'b0);
                                n_nres = 3'd1;
                            end
                        end
                    end
                    OP_ERASE: if (r_ecnt != '0) begin
                        n_ecnt = r_ecnt - 1'b1;
                        if (i_mode[6]) begin
                            n_res[0] = mk(K_RUBOUT, 8'd0, 9'd1, 1'b0); n_nres = 3'd1;
                        end
                    end
                    OP_KILL: begin
                        if (i_mode[7] && r_ecnt != '0) begin
                            n_res[0] = mk(K_RUBOUT, 8'd0, kill_n, 1'b0); n_nres = 3'd1;
                        end
                        n_ecnt = '0;
                    end
                    OP_EOF: if (r_ecnt == '0) n_eofp = 1'b1;
                    OP_READ: begin
                        if (r_rcnt == '0) begin
                            if (r_eofp) begin
                                n_eofp = 1'b0; n_res[0] = mk(K_EOF, 8'd0, 9'd0, 1'b0);
                            end else n_res[0] = mk(K_EMPTY, 8'd0, 9'd0, 1'b0);
                            n_nres = 3'd1;
                        end
                    end
                    OP_DISCARD: begin
                        n_ecnt = '0; n_rcnt = '0; n_head = '0;
                    end
                    default: ;
                endcase
            end
            ST_COMMIT: begin
                // one edit byte a cycle; read data lands the cycle after its address
                e_ra = r_ci[LA-1:0] + 1'b1;
                if (r_ci != '0 || 1'b1) begin
                    q_wd = e_rd;
                    if (r_rcnt != (QA+1)'(QUEUE_DEPTH)) begin
                        q_we = 1'b1; n_rcnt = r_rcnt + 1'b1;
                    end
                end
                n_ci = r_ci + 1'b1;
                if (r_ci + 1'b1 >= r_ecnt) n_ecnt = '0;
            end
            ST_RDWAIT: begin
                n_res[0] = mk(K_READ, q_rd, 9'd0, i_mode[4] && q_rd == CH_NL);
                n_nres = 3'd1;
                n_head = r_head + 1'b1;
                n_rcnt = r_rcnt - 1'b1;
            end
            ST_EMIT: begin
                if (ofree && r_ri < r_nres) begin
                    n_out = r_res[r_ri];
                    n_out.last = (r_ri + 1'b1 == r_nres);
                    n_ov = 1'b1;
                    n_ri = r_ri + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 5; k++) r_res[k] <= n_res[k];
        r_out <= n_out;
        r_ci <= n_ci; r_nres <= n_nres; r_ri <= n_ri;
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ecnt <= '0; r_head <= '0; r_rcnt <= '0;
            r_eofp <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ecnt <= n_ecnt; r_head <= n_head; r_rcnt <= n_rcnt;
            r_eofp <= n_eofp; r_ov <= n_ov;
        end
    end
endmodule

### rtl/core/terminal_line_discipline.sv
// Top level of the terminal line discipline
//  channel  | dir | payload
//  in_ch    | in  | cmd, in_byte
//  out_ch   | out | result_kind, data_byte, rubout_count, line_end, last
//  cfg_ch   | in  | index, wdata
// The back part takes each item through execute and emit states, and a read that
// finds ring data also passes a wait state for the registered ring read. A line
// commit moves one edit byte per cycle, set by the single edit-store read port.
// Synchronous active-low reset clears state, counts, pointers; loads config defaults.
// A stalled output holds the back part; the four-entry task queue keeps accepting
// until full, then input stalls. Configuration is taken only when all is idle.
module terminal_line_discipline #(
    parameter int LINE_DEPTH  = tld_pkg::LINE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = tld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tld_in_if.sink     in_ch,
    tld_out_if.source  out_ch,
    tld_cfg_if.sink    cfg_ch
);
    import tld_pkg::*;
    logic [8:0] r_mode;
    logic [7:0] r_intr, r_quit, r_susp, r_erase, r_kill, r_eofc;
    logic push, full, pop, empty, idle;
    t_task t_in, t_out;

    assign cfg_ch.ready = idle;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 9'd505; r_intr <= 8'd3; r_quit <= 8'd28; r_susp <= 8'd26;
            r_erase <= 8'd127; r_kill <= 8'd21; r_eofc <= 8'd4;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                REG_MODE:  r_mode <= cfg_ch.wdata;
                REG_INTR:  r_intr <= cfg_ch.wdata[7:0];
                REG_QUIT:  r_quit <= cfg_ch.wdata[7:0];
                REG_SUSP:  r_susp <= cfg_ch.wdata[7:0];
                REG_ERASE: r_erase <= cfg_ch.wdata[7:0];
                REG_KILL:  r_kill <= cfg_ch.wdata[7:0];
                REG_EOF:   r_eofc <= cfg_ch.wdata[7:0];
                default: ;
            endcase
        end
    end

    tld_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .i_mode(r_mode),
        .i_intr(r_intr), .i_quit(r_quit), .i_susp(r_susp), .i_erase(r_erase),
        .i_kill(r_kill), .i_eofc(r_eofc), .o_push(push), .o_task(t_in), .i_full(full));

    tld_queue #(.DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_task(t_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_task(t_out));

    tld_back #(.LINE_DEPTH(LINE_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mode(r_mode), .i_empty(empty),
        .i_task(t_out), .o_pop(pop), .o_idle(idle), .out_ch(out_ch));
endmodule

### rtl/core/tld_checker.sv
// Port-level assertions for the terminal line discipline, with bind
`include "terminal_line_discipline_defines.svh"
module tld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [8:0] out_count,
    input logic       out_lend,
    input logic       out_last
);
    import tld_pkg::*;
    `TLD_ASSERT_NXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `TLD_ASSERT_IMP(a_cnt, i_clk, i_rst_n, out_valid && out_kind != K_RUBOUT,
        out_count == 9'd0)
    `TLD_ASSERT_IMP(a_lend, i_clk, i_rst_n, out_valid && out_lend, out_kind == K_READ)
    `TLD_ASSERT_IMP(a_read_last, i_clk, i_rst_n,
        out_valid && (out_kind == K_READ || out_kind == K_EMPTY || out_kind == K_EOF),
        out_last)
endmodule

bind terminal_line_discipline tld_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.result_kind), .out_count(out_ch.rubout_count),
    .out_lend(out_ch.line_end), .out_last(out_ch.last));

### sim/tb.sv
// Self-checking testbench for the terminal line discipline
`timescale 1ns / 100ps

module tb;
    import tld_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE = 600;
    // mode bit positions
    localparam int MB_CRNL = 0, MB_IGNCR = 1, MB_NLCR = 2, MB_SIG = 3, MB_CANON = 4;
    localparam int MB_ECHO = 5, MB_ECHOE = 6, MB_ECHOK = 7, MB_ONLCR = 8;

    logic i_clk;
    logic i_rst_n;

    tld_in_if  in_ch ();
    tld_out_if out_ch ();
    tld_cfg_if cfg_ch ();

    terminal_line_discipline i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    // clock, 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow copy of the line discipline state
    logic [8:0] tty_mode;
    logic [7:0] ch_intr, ch_quit, ch_susp, ch_erase, ch_kill, ch_eof;
    logic [7:0] line_buf [256];
    int         line_len;
    logic [7:0] cooked_ring [256];
    int         ring_head, ring_cnt;
    bit         eof_flag;

    t_result    item_words[$];
    t_result    expected_words[$];

    int  errors;
    int  idle_cycles;
    bit  calm;
    bit  hold_req;
    int  hold_left;
    int  stall_left;

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    function automatic void add_word(logic [2:0] kind, logic [7:0] data, int cnt, bit lend);
        t_result w;
        if (item_words.size() >= 5) return;
        w.kind  = kind;
        w.data  = data;
        w.count = (cnt > 511) ? 9'd511 : cnt[8:0];
        w.lend  = lend;
        w.last  = 1'b0;
        item_words.push_back(w);
    endfunction

    function automatic void echo_char(logic [7:0] c);
        if (c == CH_NL && tty_mode[MB_ONLCR]) add_word(K_ECHO, CH_CR, 0, 0);
        add_word(K_ECHO, c, 0, 0);
    endfunction

    function automatic void ring_push(logic [7:0] c);
        if (ring_cnt >= 256) return;
        cooked_ring[(ring_head + ring_cnt) % 256] = c;
        ring_cnt++;
    endfunction

    function automatic void commit_line();
        for (int i = 0; i < line_len; i++) ring_push(line_buf[i]);
        line_len = 0;
    endfunction

    // one received byte through translation, signals and line editing
    function automatic void take_byte(logic [7:0] b);
        logic [7:0] c;
        int sig;
        c = b;
        sig = -1;
        if (tty_mode[MB_CRNL]) begin
            if (c == CH_CR) c = CH_NL;
        end else if (tty_mode[MB_IGNCR] && c == CH_CR) begin
            return;
        end
        if (tty_mode[MB_NLCR] && c == CH_NL) c = CH_CR;

        if (tty_mode[MB_SIG]) begin
            if (c == ch_intr) sig = 0;
            else if (c == ch_quit) sig = 1;
            else if (c == ch_susp) sig = 2;
            if (sig >= 0) begin
                line_len = 0;
                if (tty_mode[MB_ECHO]) begin
                    echo_char(CH_CARET);
                    echo_char(CH_AT + c);
                    echo_char(CH_NL);
                end
                add_word(K_SIGNAL, sig[7:0], 0, 0);
                return;
            end
        end

        if (!tty_mode[MB_CANON]) begin
            ring_push(c);
            if (tty_mode[MB_ECHO]) echo_char(c);
            return;
        end

        if (c == ch_erase || c == CH_BS) begin
            if (line_len > 0) begin
                line_len--;
                if (tty_mode[MB_ECHOE]) add_word(K_RUBOUT, 8'd0, 1, 0);
            end
        end else if (c == ch_kill) begin
            if (tty_mode[MB_ECHOK] && line_len > 0) add_word(K_RUBOUT, 8'd0, line_len, 0);
            line_len = 0;
        end else if (c == ch_eof) begin
            if (line_len == 0) eof_flag = 1'b1;
            else commit_line();
        end else if (c == CH_NL) begin
            if (line_len < 256) line_buf[line_len++] = c;
            if (tty_mode[MB_ECHO]) echo_char(CH_NL);
            commit_line();
        end else if (line_len < 256) begin
            line_buf[line_len++] = c;
            if (tty_mode[MB_ECHO]) echo_char(c);
        end
    endfunction

    // expected words for one accepted input word
    function automatic void predict_tty(logic [1:0] cmd, logic [7:0] b);
        logic [7:0] rb;
        item_words.delete();
        case (cmd)
            CMD_RECV: take_byte(b);
            CMD_READ: begin
                if (ring_cnt > 0) begin
                    rb = cooked_ring[ring_head];
                    ring_head = (ring_head + 1) % 256;
                    ring_cnt--;
                    add_word(K_READ, rb, 0, tty_mode[MB_CANON] && rb == CH_NL);
                end else if (eof_flag) begin
                    eof_flag = 1'b0;
                    add_word(K_EOF, 8'd0, 0, 0);
                end else begin
                    add_word(K_EMPTY, 8'd0, 0, 0);
                end
            end
            CMD_DISCARD: begin
                line_len = 0;
                ring_cnt = 0;
                ring_head = 0;
            end
            default: ;
        endcase
        if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
    endfunction

    // send one word; typed_n >= 0 gives a hand-written expectation
    task automatic send_word(logic [1:0] cmd, logic [7:0] b, int typed_n = -1,
                             t_result typed = '0);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.cmd     = cmd;
        in_ch.in_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_tty(cmd, b);
        if (typed_n >= 0) begin
            item_words.delete();
            if (typed_n > 0) item_words.push_back(typed);
        end
        foreach (item_words[i]) expected_words.push_back(item_words[i]);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_MODE:  tty_mode = val;
            REG_INTR:  ch_intr  = val[7:0];
            REG_QUIT:  ch_quit  = val[7:0];
            REG_SUSP:  ch_susp  = val[7:0];
            REG_ERASE: ch_erase = val[7:0];
            REG_KILL:  ch_kill  = val[7:0];
            REG_EOF:   ch_eof   = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // let the block go idle: all results in, then its latency
    task automatic drain_tty();
        in_ch.valid = 1'b0;
        wait (expected_words.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic load_regs(logic [8:0] m, logic [7:0] a, logic [7:0] q, logic [7:0] s,
                             logic [7:0] e, logic [7:0] k, logic [7:0] f);
        drain_tty();
        write_reg(REG_MODE, m);
        write_reg(REG_INTR, {1'b0, a});
        write_reg(REG_QUIT, {1'b0, q});
        write_reg(REG_SUSP, {1'b0, s});
        write_reg(REG_ERASE, {1'b0, e});
        write_reg(REG_KILL, {1'b0, k});
        write_reg(REG_EOF, {1'b0, f});
    endtask

    // typing-like byte: mostly text, some line ends and control chars
    function automatic logic [7:0] typed_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
        if (r < 68) return ($urandom_range(0, 1) != 0) ? CH_NL : CH_CR;
        if (r < 85) begin
            case ($urandom_range(0, 6))
                0: return ch_intr;
                1: return ch_quit;
                2: return ch_susp;
                3: return ch_erase;
                4: return ch_kill;
                5: return ch_eof;
                default: return CH_BS;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_burst(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 62) send_word(CMD_RECV, typed_byte());
            else if (r < 95) send_word(CMD_READ, 8'($urandom_range(0, 255)));
            else if (r < 98) send_word(CMD_DISCARD, 8'($urandom_range(0, 255)));
            else send_word(CMD_SPARE, 8'($urandom_range(0, 255)));
        end
    endtask

    // directed rows
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] b;
        int         n;      // -1: predicted, else count of typed words
        t_result    w;
    } t_row;
    t_row dir_rows[$];

    function automatic void row(logic [1:0] cmd, logic [7:0] b, int n = -1,
                                logic [2:0] kind = K_ECHO, logic [7:0] data = 8'd0,
                                logic [8:0] cnt = 9'd0);
        t_row x;
        x.cmd = cmd;
        x.b = b;
        x.n = n;
        x.w.kind = kind;
        x.w.data = data;
        x.w.count = cnt;
        x.w.lend = 1'b0;
        x.w.last = 1'b1;
        dir_rows.push_back(x);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                flag_error($sformatf("unexpected word kind %0d data %02h",
                                     out_ch.result_kind, out_ch.data_byte));
            end else begin
                t_result w;
                w = expected_words.pop_front();
                if (out_ch.result_kind !== w.kind || out_ch.data_byte !== w.data ||
                    out_ch.rubout_count !== w.count || out_ch.line_end !== w.lend ||
                    out_ch.last !== w.last)
                    flag_error($sformatf("exp k%0d d%02h c%0d e%0b l%0b got k%0d d%02h c%0d e%0b l%0b",
                        w.kind, w.data, w.count, w.lend, w.last, out_ch.result_kind,
                        out_ch.data_byte, out_ch.rubout_count, out_ch.line_end, out_ch.last));
            end
        end
    end

    // receiver stalls: random bursts, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= 300;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_RECV;
        in_ch.in_byte = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MODE;
        cfg_ch.wdata = 9'd0;
        out_ch.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        tty_mode = 9'd505;
        ch_intr = 8'd3;
        ch_quit = 8'd28;
        ch_susp = 8'd26;
        ch_erase = 8'd127;
        ch_kill = 8'd21;
        ch_eof = 8'd4;
        line_len = 0;
        ring_head = 0;
        ring_cnt = 0;
        eof_flag = 1'b0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset settings
        row(CMD_READ, 8'h00, 1, K_EMPTY);
        row(CMD_SPARE, 8'hFF, 0);
        row(CMD_RECV, "a", 1, K_ECHO, "a");
        row(CMD_RECV, 8'hFF, 1, K_ECHO, 8'hFF);
        row(CMD_RECV, 8'h00, 1, K_ECHO, 8'h00);
        row(CMD_RECV, 8'd127, 1, K_RUBOUT, 8'd0, 9'd1);
        row(CMD_RECV, CH_BS, 1, K_RUBOUT, 8'd0, 9'd1);
        row(CMD_RECV, 8'd21, 1, K_RUBOUT, 8'd0, 9'd1);
        row(CMD_RECV, 8'd127, 0);
        row(CMD_RECV, 8'd21, 0);
        row(CMD_RECV, 8'd4, 0);
        row(CMD_RECV, "x");
        row(CMD_RECV, CH_CR);
        row(CMD_READ, 8'h00);
        row(CMD_READ, 8'h00);
        row(CMD_READ, 8'h00, 1, K_EOF);
        row(CMD_READ, 8'h00, 1, K_EMPTY);
        row(CMD_RECV, 8'd3);
        row(CMD_RECV, 8'd28);
        row(CMD_RECV, 8'd26);
        row(CMD_RECV, "q");
        row(CMD_RECV, 8'd4);
        row(CMD_DISCARD, 8'h00, 0);
        row(CMD_READ, 8'h00, 1, K_EMPTY);
        @(negedge i_clk);
        foreach (dir_rows[i]) send_word(dir_rows[i].cmd, dir_rows[i].b, dir_rows[i].n,
                                        dir_rows[i].w);

        // random text at reset settings, with a long receiver hold-off
        random_burst(15);
        hold_req = 1'b1;
        random_burst(15);
        in_ch.valid = 1'b0;
        wait (expected_words.size() == 0);
        @(negedge i_clk);
        random_burst(5);

        // all mode bits, control chars at zero
        load_regs(9'h1FF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        random_burst(20);

        // raw mode, no echo, control chars at 255
        load_regs(9'h000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_DISCARD, 8'h00);
        for (int i = 0; i < 10; i++) send_word(CMD_RECV, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 12; i++) send_word(CMD_READ, 8'h00);

        // canonical with full echo: overfill the edit line, fill and overfill
        // the ring by line commits, then a multi-byte kill
        load_regs(9'h0F8, 8'd3, 8'd28, 8'd26, 8'd127, 8'd21, 8'd4);
        send_word(CMD_DISCARD, 8'h00);
        for (int i = 0; i < 258; i++) send_word(CMD_RECV, 8'($urandom_range(8'h20, 8'h7E)));
        send_word(CMD_RECV, CH_NL);
        send_word(CMD_RECV, "z");
        send_word(CMD_RECV, CH_NL);
        for (int i = 0; i < 3; i++) send_word(CMD_READ, 8'h00);
        for (int i = 0; i < 20; i++) send_word(CMD_RECV, 8'($urandom_range(8'h20, 8'h7E)));
        send_word(CMD_RECV, 8'd21);
        send_word(CMD_DISCARD, 8'h00);

        // random settings, quiet handshakes in the last one
        for (int p = 0; p < 2; p++) begin
            load_regs(9'($urandom_range(0, 511)), 8'($urandom_range(0, 31)),
                      8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 31)),
                      8'($urandom_range(0, 31)));
            if (p == 1) calm = 1'b1;
            random_burst(15);
        end

        in_ch.valid = 1'b0;
        wait (expected_words.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
